/* design/pgvu_pkg.sv */
// Package: widths, stage map, register codes and pipeline types of the point gravity unit.
package pgvu_pkg;

   localparam int FRAC    = 16;             // fraction bits of every fixed-point value
   localparam int AXES    = 3;
   localparam int DW      = 32;             // position / velocity field width
   localparam int MW      = DW + 1;         // |center - pos| and distance width
   localparam int FSW     = 48;             // force_scale width
   localparam int MDW     = 23;             // min_distance width
   localparam int TSW     = 17;             // time_step width
   localparam int CSR_IW  = 3;              // register index width
   localparam int FS_HALF = FSW / 2;
   localparam int FPW     = FS_HALF + MW;   // force_scale half times magnitude
   localparam int N1W     = FSW + MW;       // force_scale times magnitude
   localparam int CHUNK   = N1W / 3;        // slice of N1W multiplied by time_step
   localparam int TPW     = CHUNK + TSW;
   localparam int NUMW    = FSW + MW + TSW; // force_scale * |d| * time_step
   localparam int NW      = NUMW + FRAC;    // dividend
   localparam int QW      = 34;             // quotient bits kept; larger quotients cap
   localparam int SQW     = 2 * MW;         // squares and distance squared
   localparam int RTW     = SQW + 2;        // square root remainder
   localparam int D3W     = 3 * MW;         // distance cubed
   localparam int RW      = D3W + 1;        // division remainder
   localparam int SUMW    = QW + 1;         // velocity plus increment

   // stage map
   localparam int ST_DIFF    = 0;
   localparam int ST_MUL1    = 1;
   localparam int ST_SUM     = 2;
   localparam int ST_MUL2    = 3;
   localparam int ST_NUM     = 4;
   localparam int ST_SQRT0   = 5;
   localparam int ST_CLAMP   = ST_SQRT0 + MW;
   localparam int ST_D2      = ST_CLAMP + 1;
   localparam int ST_D3P     = ST_D2 + 1;
   localparam int ST_D3      = ST_D3P + 1;
   localparam int ST_DIVINIT = ST_D3 + 1;
   localparam int ST_DIV0    = ST_DIVINIT + 1;
   localparam int ST_OUT     = ST_DIV0 + QW;
   localparam int NSTAGE     = ST_OUT + 1;

   typedef enum logic [CSR_IW-1:0] {
      CSR_FORCE_SCALE  = 3'd0,
      CSR_MIN_DISTANCE = 3'd1,
      CSR_CENTER_X     = 3'd2,
      CSR_CENTER_Y     = 3'd3,
      CSR_CENTER_Z     = 3'd4,
      CSR_TIME_STEP    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [FSW-1:0]            force_scale;
      logic [MDW-1:0]            min_distance;
      logic [AXES-1:0][DW-1:0]   center;
      logic [TSW-1:0]            time_step;
   } cfg_type;

   typedef struct packed {
      logic [AXES-1:0][DW-1:0]         vel;    // input velocity, result at last stage
      logic [AXES-1:0]                 neg;
      logic [AXES-1:0][MW-1:0]         mag;
      logic [AXES-1:0][1:0][FPW-1:0]   fp;
      logic [AXES-1:0][SQW-1:0]        sq;
      logic [SQW-1:0]                  ssum;
      logic [AXES-1:0][NUMW-1:0]       num;
      logic [AXES-1:0][2:0][TPW-1:0]   tp;
      logic [RTW-1:0]                  srem;
      logic [MW-1:0]                   root;
      logic [MW-1:0]                   clamp_len;
      logic                            dz;
      logic [SQW-1:0]                  d2;
      logic [1:0][SQW-1:0]             d3p;
      logic [D3W-1:0]                  dist3;
      logic [AXES-1:0][RW-1:0]         rem;
      logic [AXES-1:0][QW-1:0]         quo;
      logic [AXES-1:0]                 ovf;
   } item_type;

endpackage

/* design/pgvu_req_if.sv */
// Interface: particle item channel (position and velocity).
interface pgvu_req_if import pgvu_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic signed [DW-1:0] pos_x;
   logic signed [DW-1:0] pos_y;
   logic signed [DW-1:0] pos_z;
   logic signed [DW-1:0] vel_x;
   logic signed [DW-1:0] vel_y;
   logic signed [DW-1:0] vel_z;

   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

/* design/pgvu_rsp_if.sv */
// Interface: updated velocity item channel.
interface pgvu_rsp_if import pgvu_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic signed [DW-1:0] new_vel_x;
   logic signed [DW-1:0] new_vel_y;
   logic signed [DW-1:0] new_vel_z;

   modport source (output valid, new_vel_x, new_vel_y, new_vel_z, input ready);
   modport sink   (input valid, new_vel_x, new_vel_y, new_vel_z, output ready);
endinterface

/* design/point_gravity_velocity_update_unit.sv */
// Top level: inverse-square point attractor, one Euler velocity step per particle.
//
//  channel   dir  handshake      payload
//  req_chan  in   valid/ready    pos_x pos_y pos_z vel_x vel_y vel_z (signed Q15.16)
//  rsp_chan  out  valid/ready    new_vel_x new_vel_y new_vel_z (signed Q15.16, saturated)
//  csr_*     in   csr_we         csr_index, csr_wdata (48 bit)
//
//  One item per cycle sustained while rsp_chan is ready; a pipeline of NSTAGE stages, among
//  them the 33 square root stages and the 34 restoring division stages per axis.
//  Reset (synchronous) empties the pipeline and loads register defaults.
//  Each stage loads when it is empty or the stage after it moves, so bubbles
//  collapse under a stalled output and items keep entering until the pipe is full.
module point_gravity_velocity_update_unit import pgvu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   pgvu_req_if.sink           req_chan,
   pgvu_rsp_if.source         rsp_chan,
   input  logic               csr_we,
   input  logic [CSR_IW-1:0]  csr_index,
   input  logic [FSW-1:0]     csr_wdata
);

   cfg_type  cfg_ff;
   item_type in_item;
   item_type pipe_ff  [NSTAGE];
   item_type stage_in [NSTAGE];
   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] en;

   // ---------------- configuration registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.force_scale  <= '0;
         cfg_ff.min_distance <= MDW'(65536);
         cfg_ff.center       <= '0;
         cfg_ff.time_step    <= TSW'(1092);
      end else if (csr_we) begin
         case (csr_index)
            CSR_FORCE_SCALE:  cfg_ff.force_scale  <= csr_wdata;
            CSR_MIN_DISTANCE: cfg_ff.min_distance <= csr_wdata[MDW-1:0];
            CSR_CENTER_X:     cfg_ff.center[0]    <= csr_wdata[DW-1:0];
            CSR_CENTER_Y:     cfg_ff.center[1]    <= csr_wdata[DW-1:0];
            CSR_CENTER_Z:     cfg_ff.center[2]    <= csr_wdata[DW-1:0];
            CSR_TIME_STEP:    cfg_ff.time_step    <= csr_wdata[TSW-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- per-stage work ----------------
   function automatic item_type stage_fn(input int k, input item_type x, input cfg_type c);
      item_type y;
      int a;
      int j;
      int b;
      int i;
      logic [RTW-1:0] t;
      logic [RW-1:0] r;
      logic [NW-1:0] n;
      logic [QW-1:0] qm;
      logic [SUMW-1:0] si;
      logic signed [SUMW-1:0] sum;
      logic [MW-1:0] dv;
      y = x;
      if (k == ST_MUL1) begin
         for (a = 0; a < AXES; a++) begin
            y.sq[a]    = SQW'(x.mag[a]) * SQW'(x.mag[a]);
            y.fp[a][0] = FPW'(c.force_scale[FS_HALF-1:0]) * FPW'(x.mag[a]);
            y.fp[a][1] = FPW'(c.force_scale[FSW-1:FS_HALF]) * FPW'(x.mag[a]);
         end
      end else if (k == ST_SUM) begin
         y.ssum = x.sq[0] + x.sq[1] + x.sq[2];
         for (a = 0; a < AXES; a++)
            y.num[a] = (NUMW'(x.fp[a][1]) << FS_HALF) + NUMW'(x.fp[a][0]);
      end else if (k == ST_MUL2) begin
         for (a = 0; a < AXES; a++)
            for (j = 0; j < 3; j++)
               y.tp[a][j] = TPW'(x.num[a][CHUNK*j +: CHUNK]) * TPW'(c.time_step);
      end else if (k == ST_NUM) begin
         for (a = 0; a < AXES; a++)
            y.num[a] = NUMW'(x.tp[a][0]) + (NUMW'(x.tp[a][1]) << CHUNK)
                     + (NUMW'(x.tp[a][2]) << (2*CHUNK));
         y.srem = RTW'(x.ssum);
         y.root = '0;
      end else if (k >= ST_SQRT0 && k < ST_CLAMP) begin
         // one result bit per stage, most significant first
         b = MW - 1 - (k - ST_SQRT0);
         t = (RTW'(x.root) << (b + 1)) | (RTW'(1) << (2 * b));
         if (x.srem >= t) begin
            y.srem = x.srem - t;
            y.root = x.root | (MW'(1) << b);
         end
      end else if (k == ST_CLAMP) begin
         dv = (x.root < MW'(c.min_distance)) ? MW'(c.min_distance) : x.root;
         y.clamp_len = dv;
         y.dz        = (dv == '0);
      end else if (k == ST_D2) begin
         y.d2 = SQW'(x.clamp_len) * SQW'(x.clamp_len);
      end else if (k == ST_D3P) begin
         y.d3p[0] = SQW'(x.d2[MW-1:0]) * SQW'(x.clamp_len);
         y.d3p[1] = SQW'(x.d2[SQW-1:MW]) * SQW'(x.clamp_len);
      end else if (k == ST_D3) begin
         y.dist3 = D3W'(x.d3p[0]) + (D3W'(x.d3p[1]) << MW);
      end else if (k == ST_DIVINIT) begin
         // quotient of 2^QW or more always caps
         for (a = 0; a < AXES; a++) begin
            n = NW'(x.num[a]) << FRAC;
            y.ovf[a] = (NW'(x.dist3) <= (n >> QW));
            y.rem[a] = RW'(n >> QW);
            y.quo[a] = '0;
         end
      end else if (k >= ST_DIV0 && k < ST_OUT) begin
         i = QW - 1 - (k - ST_DIV0);
         for (a = 0; a < AXES; a++) begin
            n = NW'(x.num[a]) << FRAC;
            r = {x.rem[a][RW-2:0], n[i]};
            if (r >= RW'(x.dist3)) begin
               r = r - RW'(x.dist3);
               y.quo[a][i] = 1'b1;
            end
            y.rem[a] = r;
         end
      end else if (k == ST_OUT) begin
         for (a = 0; a < AXES; a++) begin
            qm = (x.ovf[a] || x.quo[a] > (QW'(1) << (QW - 1))) ? (QW'(1) << (QW - 1))
                                                                : x.quo[a];
            si = x.dz ? '0 : SUMW'(qm);
            sum = $signed(SUMW'($signed(x.vel[a]))) + (x.neg[a] ? -$signed(si) : $signed(si));
            if (sum[SUMW-1:DW-1] == '0 || sum[SUMW-1:DW-1] == '1)
               y.vel[a] = sum[DW-1:0];
            else if (sum[SUMW-1])
               y.vel[a] = {1'b1, {(DW-1){1'b0}}};
            else
               y.vel[a] = {1'b0, {(DW-1){1'b1}}};
         end
      end
      return y;
   endfunction

   // stage 0: vector from particle to center, split into sign and magnitude
   always_comb begin
      logic [AXES-1:0][DW-1:0] pos;
      logic [MW-1:0] dd;
      pos = {req_chan.pos_z, req_chan.pos_y, req_chan.pos_x};
      in_item = '0;
      in_item.vel = {req_chan.vel_z, req_chan.vel_y, req_chan.vel_x};
      for (int a = 0; a < AXES; a++) begin
         dd = {cfg_ff.center[a][DW-1], cfg_ff.center[a]} - {pos[a][DW-1], pos[a]};
         in_item.neg[a] = dd[MW-1];
         in_item.mag[a] = dd[MW-1] ? (MW'(0) - dd) : dd;
      end
   end

   // ---------------- pipeline ----------------
   assign stage_in[0] = in_item;

   for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
      if (k > 0) begin : g_fn
         assign stage_in[k] = stage_fn(k, pipe_ff[k-1], cfg_ff);
      end
      if (k == NSTAGE - 1) begin : g_last
         assign en[k] = !valid_ff[k] || rsp_chan.ready;
      end else begin : g_mid
         assign en[k] = !valid_ff[k] || en[k+1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en[k]) begin
            valid_ff[k] <= (k == 0) ? req_chan.valid : valid_ff[(k == 0) ? 0 : k - 1];
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            pipe_ff[k] <= stage_in[k];
         end
      end
   end

   assign req_chan.ready     = en[0];
   assign rsp_chan.valid     = valid_ff[NSTAGE-1];
   assign rsp_chan.new_vel_x = $signed(pipe_ff[NSTAGE-1].vel[0]);
   assign rsp_chan.new_vel_y = $signed(pipe_ff[NSTAGE-1].vel[1]);
   assign rsp_chan.new_vel_z = $signed(pipe_ff[NSTAGE-1].vel[2]);

   // ---------------- assertions ----------------
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> valid_ff[0])
      else $error("accepted item did not enter first stage");

   a_backpressure_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (valid_ff[NSTAGE-1] && !rsp_chan.ready))
      else $error("input stalled without a stalled output");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_OUT-1] && !pipe_ff[ST_OUT-1].ovf[0])
         |-> (pipe_ff[ST_OUT-1].rem[0] < RW'(pipe_ff[ST_OUT-1].dist3)))
      else $error("division remainder not below divisor");

endmodule
